/* rtl/flim_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flim_pkg
// Shared types, register map and constants of the fabric link error
// isolation monitor.
// ----------------------------------------------------------------------------
package flim_pkg;

    localparam int LANE_COUNT_DEF = 256;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 336;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_CRC_ISOLATE  = 3'd0;
    localparam logic [2:0] REG_CRC_RECOVER  = 3'd1;
    localparam logic [2:0] REG_FEC_ISOLATE  = 3'd2;
    localparam logic [2:0] REG_FEC_RECOVER  = 3'd3;
    localparam logic [2:0] REG_RATE_CRC     = 3'd4;
    localparam logic [2:0] REG_RATE_RX      = 3'd5;
    localparam logic [2:0] REG_SKIP_POLLS   = 3'd6;

    localparam logic [7:0]  CRC_ISOLATE_DEF = 8'd1;
    localparam logic [7:0]  CRC_RECOVER_DEF = 8'd8;
    localparam logic [7:0]  FEC_ISOLATE_DEF = 8'd2;
    localparam logic [7:0]  FEC_RECOVER_DEF = 8'd8;
    localparam logic [31:0] RATE_CRC_DEF    = 32'd1;
    localparam logic [31:0] RATE_RX_DEF     = 32'd61035156;
    localparam logic [7:0]  SKIP_POLLS_DEF  = 8'd20;
    localparam logic [7:0]  TEST_SKIP_LIMIT = 8'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ISOLATE = 2'd1;
    localparam logic [1:0] EV_RECOVER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_CMP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_rec;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic cmp;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [7:0]  crc_isolate;
        logic [7:0]  crc_recover;
        logic [7:0]  fec_isolate;
        logic [7:0]  fec_recover;
        logic [31:0] rate_crc;
        logic [31:0] rate_rx;
        logic [7:0]  skip_polls;
    } cfg_t;

    // input item, lowest field in the lowest bits
    typedef struct packed {
        logic [63:0] test_fec_errors;
        logic [63:0] inj_crc_errors;
        logic        link_up;
        logic [63:0] fec_uncorrectable;
        logic [63:0] crc_error_cells;
        logic [63:0] rx_cell_count;
        logic [7:0]  lane;
    } in_t;

    typedef struct packed {
        logic        rate_exceeded;
        logic [7:0]  fec_clean_polls;
        logic [7:0]  fec_error_polls;
        logic [7:0]  crc_clean_polls;
        logic [7:0]  crc_error_polls;
        logic [1:0]  isolation_event;
        logic        isolated;
        logic [7:0]  lane_out;
    } out_t;

    // per-lane record held in the lane memory
    typedef struct packed {
        logic        isolated;
        logic [7:0]  crc_skip;
        logic [7:0]  fec_skip;
        logic [7:0]  crc_bad;
        logic [7:0]  crc_good;
        logic [7:0]  fec_bad;
        logic [7:0]  fec_good;
        logic [63:0] last_rx;
        logic [63:0] last_crc;
        logic [63:0] last_fec;
    } rec_t;

endpackage
`default_nettype wire

/* rtl/flim_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flim_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module flim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/flim_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flim_cfg
// APB register file holding the thresholds, rate limit and skip count.
// ----------------------------------------------------------------------------
module flim_cfg
    import flim_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_isolate <= CRC_ISOLATE_DEF;
            cfg_reg.crc_recover <= CRC_RECOVER_DEF;
            cfg_reg.fec_isolate <= FEC_ISOLATE_DEF;
            cfg_reg.fec_recover <= FEC_RECOVER_DEF;
            cfg_reg.rate_crc    <= RATE_CRC_DEF;
            cfg_reg.rate_rx     <= RATE_RX_DEF;
            cfg_reg.skip_polls  <= SKIP_POLLS_DEF;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CRC_ISOLATE: cfg_reg.crc_isolate <= pwdata[7:0];
                REG_CRC_RECOVER: cfg_reg.crc_recover <= pwdata[7:0];
                REG_FEC_ISOLATE: cfg_reg.fec_isolate <= pwdata[7:0];
                REG_FEC_RECOVER: cfg_reg.fec_recover <= pwdata[7:0];
                REG_RATE_CRC:    cfg_reg.rate_crc    <= pwdata;
                REG_RATE_RX:     cfg_reg.rate_rx     <= pwdata;
                REG_SKIP_POLLS:  cfg_reg.skip_polls  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CRC_ISOLATE: prdata = {24'd0, cfg_reg.crc_isolate};
            REG_CRC_RECOVER: prdata = {24'd0, cfg_reg.crc_recover};
            REG_FEC_ISOLATE: prdata = {24'd0, cfg_reg.fec_isolate};
            REG_FEC_RECOVER: prdata = {24'd0, cfg_reg.fec_recover};
            REG_RATE_CRC:    prdata = cfg_reg.rate_crc;
            REG_RATE_RX:     prdata = cfg_reg.rate_rx;
            REG_SKIP_POLLS:  prdata = {24'd0, cfg_reg.skip_polls};
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/flim_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flim_ctrl
// Sequencer for one poll: record read, split multiply, compare, write back.
// ----------------------------------------------------------------------------
module flim_ctrl
    import flim_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   s_fire;

    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_CMP;
            ST_CMP:    state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                // hold until the result register can take the transaction
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_READ:   cmd.load_rec = 1'b1;
            ST_MUL_LO: cmd.mul_lo   = 1'b1;
            ST_MUL_HI: cmd.mul_hi   = 1'b1;
            ST_SUM:    cmd.sum      = 1'b1;
            ST_CMP:    cmd.cmp      = 1'b1;
            ST_UPDATE: cmd.update   = status.out_free;
            default:   ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> state_reg == ST_READ)
        else $error("accepted poll did not start a record read");

    a_update_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE && !status.out_free |=> state_reg == ST_UPDATE)
        else $error("update left while result register was full");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");
`endif

endmodule
`default_nettype wire

/* rtl/flim_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flim_dp
// Datapath: lane record memory, counter differences, rate products,
// run counters, isolation decision and result register.
// ----------------------------------------------------------------------------
module flim_dp
    import flim_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire in_t                   s_item,
    input  wire logic                  s_test,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = (LANE_COUNT < 256) ? LANE_COUNT : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REC_W = $bits(rec_t);

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        logic [7:0] r;
        r = (v == 8'hFF) ? v : v + 8'd1;
        return r;
    endfunction

    // returns {bad_run, good_run}
    function automatic logic [15:0] run_step(input logic bad, input logic [7:0] bthr,
                                             input logic [7:0] gthr,
                                             input logic [7:0] brun,
                                             input logic [7:0] grun);
        logic [7:0] b;
        logic [7:0] g;
        b = brun;
        g = grun;
        if (bad)
        begin
            if (brun < bthr)
            begin
                b = brun + 8'd1;
                g = 8'd0;
            end
        end
        else if (grun < gthr)
        begin
            g = grun + 8'd1;
            b = 8'd0;
        end
        return {b, g};
    endfunction

    // captured poll
    logic [7:0]  lane_reg;
    logic [63:0] rx_reg;
    logic [63:0] crc_reg;
    logic [63:0] fec_reg;
    logic [63:0] tcrc_reg;
    logic [63:0] tfec_reg;
    logic        up_reg;
    logic        test_reg;
    logic        lane_ok_reg;
    logic        hit_reg;
    logic        lane_ok;

    logic [DEPTH-1:0] valid_reg;
    logic [REC_W-1:0] rdata;
    rec_t             rec_reg;
    rec_t             rec_rd;
    rec_t             rec_next;

    logic [63:0] drx_reg;
    logic [63:0] dcrc_reg;
    logic [63:0] dfec_reg;
    logic [63:0] pa_lo_reg;
    logic [63:0] pb_lo_reg;
    logic [63:0] pa_hi_reg;
    logic [63:0] pb_hi_reg;
    logic [95:0] pa_reg;
    logic [95:0] pb_reg;
    logic        gt_reg;

    logic        m_valid_reg;
    logic        m_valid_next;
    out_t        out_reg;
    out_t        out_next;

    logic [7:0]  skip_lim;
    logic        crc_judge;
    logic        fec_judge;
    logic [7:0]  cthr;
    logic [7:0]  fthr;
    logic [15:0] crc_runs;
    logic [15:0] fec_runs;
    logic [1:0]  ev_next;

    assign lane_ok = {24'd0, s_item.lane} < 32'(LANE_COUNT);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lane_reg    <= s_item.lane;
            rx_reg      <= s_item.rx_cell_count;
            crc_reg     <= s_item.crc_error_cells;
            fec_reg     <= s_item.fec_uncorrectable;
            tcrc_reg    <= s_item.inj_crc_errors;
            tfec_reg    <= s_item.test_fec_errors;
            up_reg      <= s_item.link_up;
            test_reg    <= s_test;
            lane_ok_reg <= lane_ok;
            hit_reg     <= lane_ok && valid_reg[s_item.lane[AW-1:0]];
        end
    end

    flim_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_lane_ram (
        .clk   (clk),
        .we    (cmd.update && lane_ok_reg),
        .waddr (lane_reg[AW-1:0]),
        .wdata (rec_next),
        .re    (cmd.capture),
        .raddr (s_item.lane[AW-1:0]),
        .rdata (rdata)
    );

    // a lane never written since reset reads as an all-zero record
    assign rec_rd = hit_reg ? rec_t'(rdata) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load_rec)
        begin
            rec_reg  <= rec_rd;
            drx_reg  <= rx_reg - rec_rd.last_rx;
            dcrc_reg <= (test_reg ? tcrc_reg : crc_reg) - rec_rd.last_crc;
            dfec_reg <= (test_reg ? tfec_reg : fec_reg) - rec_rd.last_fec;
        end
        if (cmd.mul_lo)
        begin
            pa_lo_reg <= 64'(dcrc_reg[31:0]) * 64'(cfg.rate_rx);
            pb_lo_reg <= 64'(drx_reg[31:0]) * 64'(cfg.rate_crc);
        end
        if (cmd.mul_hi)
        begin
            pa_hi_reg <= 64'(dcrc_reg[63:32]) * 64'(cfg.rate_rx);
            pb_hi_reg <= 64'(drx_reg[63:32]) * 64'(cfg.rate_crc);
        end
        if (cmd.sum)
        begin
            pa_reg <= {32'd0, pa_lo_reg} + {pa_hi_reg, 32'd0};
            pb_reg <= {32'd0, pb_lo_reg} + {pb_hi_reg, 32'd0};
        end
        if (cmd.cmp)
        begin
            gt_reg <= pa_reg > pb_reg;
        end
    end

    always_comb
    begin
        skip_lim  = test_reg ? TEST_SKIP_LIMIT : cfg.skip_polls;
        crc_judge = !(rec_reg.crc_skip < skip_lim);
        fec_judge = !(rec_reg.fec_skip < skip_lim);
        // test polls raise the threshold of a judged path for this poll only
        cthr      = (test_reg && crc_judge) ? sat_inc(cfg.crc_isolate) : cfg.crc_isolate;
        fthr      = (test_reg && fec_judge) ? sat_inc(cfg.fec_isolate) : cfg.fec_isolate;
        crc_runs  = run_step(gt_reg, cthr, cfg.crc_recover,
                             rec_reg.crc_bad, rec_reg.crc_good);
        fec_runs  = run_step(dfec_reg != 64'd0, fthr, cfg.fec_recover,
                             rec_reg.fec_bad, rec_reg.fec_good);

        rec_next         = rec_reg;
        rec_next.last_rx = rx_reg;
        if (!crc_judge)
        begin
            rec_next.crc_skip = rec_reg.crc_skip + 8'd1;
            rec_next.last_crc = crc_reg;
        end
        else
        begin
            rec_next.last_crc = test_reg ? 64'd0 : crc_reg;
            rec_next.crc_bad  = crc_runs[15:8];
            rec_next.crc_good = crc_runs[7:0];
        end
        if (!fec_judge)
        begin
            rec_next.fec_skip = rec_reg.fec_skip + 8'd1;
            rec_next.last_fec = fec_reg;
        end
        else
        begin
            rec_next.last_fec = test_reg ? 64'd0 : fec_reg;
            rec_next.fec_bad  = fec_runs[15:8];
            rec_next.fec_good = fec_runs[7:0];
        end

        ev_next = EV_NONE;
        if (up_reg)
        begin
            if (!rec_reg.isolated &&
                (rec_next.crc_bad >= cthr || rec_next.fec_bad >= fthr))
            begin
                rec_next.isolated = 1'b1;
                ev_next           = EV_ISOLATE;
            end
            else if (rec_reg.isolated &&
                     rec_next.crc_good >= cfg.crc_recover &&
                     rec_next.fec_good >= cfg.fec_recover)
            begin
                rec_next.isolated = 1'b0;
                ev_next           = EV_RECOVER;
            end
        end

        out_next          = '0;
        out_next.lane_out = lane_reg;
        if (lane_ok_reg)
        begin
            out_next.isolated        = rec_next.isolated;
            out_next.isolation_event = ev_next;
            out_next.crc_error_polls = rec_next.crc_bad;
            out_next.crc_clean_polls = rec_next.crc_good;
            out_next.fec_error_polls = rec_next.fec_bad;
            out_next.fec_clean_polls = rec_next.fec_good;
            out_next.rate_exceeded   = crc_judge && gt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update && lane_ok_reg)
        begin
            valid_reg[lane_reg[AW-1:0]] <= 1'b1;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.update)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_reg <= out_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = {(OUT_DATA_W - $bits(out_t))'(0), out_reg};

`ifndef SYNTHESIS
    a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> m_valid_reg)
        else $error("update did not present a result");

    a_down_link_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && !up_reg |-> ev_next == EV_NONE)
        else $error("isolation changed while link was down");

    a_event_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && ev_next == EV_ISOLATE |-> rec_next.isolated)
        else $error("isolation event without isolated flag");

    a_bad_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && crc_judge && gt_reg && rec_reg.crc_bad < cthr
        |-> rec_next.crc_good == 8'd0)
        else $error("error poll left a clean run standing");
`endif

endmodule
`default_nettype wire

/* rtl/fabric_link_error_isolation_monitor.sv */
`default_nettype none
// A poll is accepted only while idle; the lane record read, the split 64x32
// rate products (two 32x32 multiplier steps), the sum, the compare and the
// record write back run one after another before the next poll is taken,
// and write back waits while the result register is full.
// Reset: control and config registers go to their defaults at once; every lane
// record reads as zero until its first write, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// fabric_link_error_isolation_monitor
// Per-lane CRC rate and FEC error tracking with automatic isolation and
// recovery, driven by polled cumulative counters.
// ----------------------------------------------------------------------------
module fabric_link_error_isolation_monitor
    import flim_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // lane, rx_cell_count, crc_error_cells, fec_uncorrectable, link_up,
    // inj_crc_errors, test_fec_errors, zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // test_mode
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // lane_out, isolated, isolation_event, crc_error_polls, crc_clean_polls,
    // fec_error_polls, fec_clean_polls, rate_exceeded, zero fill
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    in_t     s_item;

    assign s_item = in_t'(s_axis_tdata[$bits(in_t)-1:0]);

    flim_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    flim_dp #(
        .LANE_COUNT (LANE_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_item   (s_item),
        .s_test   (s_axis_tuser[0]),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

/* test/tb_fabric_link_error_isolation_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fabric_link_error_isolation_monitor
// Drives lane polls into the monitor over the input stream and keeps its own
// per-lane copy of the error tracking state. Each result taken from the output
// stream is checked field by field against the predicted one. Directed polls
// cover field extremes, zero and saturated thresholds, link down and injected
// counters. Random polls then run per-lane counter sequences under changing
// register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_fabric_link_error_isolation_monitor;
    import flim_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 10;
    localparam int ROUNDS        = 8;
    localparam int ROUND_POLLS   = 235;
    localparam int IN_PAD        = IN_DATA_W - $bits(in_t);

    typedef struct packed {
        logic        isolated;
        logic [7:0]  crc_skip;
        logic [7:0]  fec_skip;
        logic [7:0]  crc_bad;
        logic [7:0]  crc_good;
        logic [7:0]  fec_bad;
        logic [7:0]  fec_good;
        logic [63:0] last_rx;
        logic [63:0] last_crc;
        logic [63:0] last_fec;
    } lane_state_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // lane, rx_cell_count, crc_error_cells, fec_uncorrectable, link_up,
    // inj_crc_errors, test_fec_errors, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // test_mode
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // lane_out, isolated, isolation_event, crc_error_polls, crc_clean_polls,
    // fec_error_polls, fec_clean_polls, rate_exceeded, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // register shadow used by the predictor
    logic [7:0]  cfg_crc_isolate = CRC_ISOLATE_DEF;
    logic [7:0]  cfg_crc_recover = CRC_RECOVER_DEF;
    logic [7:0]  cfg_fec_isolate = FEC_ISOLATE_DEF;
    logic [7:0]  cfg_fec_recover = FEC_RECOVER_DEF;
    logic [31:0] cfg_rate_crc    = RATE_CRC_DEF;
    logic [31:0] cfg_rate_rx     = RATE_RX_DEF;
    logic [7:0]  cfg_skip        = SKIP_POLLS_DEF;

    lane_state_t lane_db [256];

    // per-lane source counters for well-formed poll sequences
    logic [63:0] src_rx  [256];
    logic [63:0] src_crc [256];
    logic [63:0] src_fec [256];
    bit          src_bad [256];

    out_t poll_results_q [$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    fabric_link_error_isolation_monitor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL fabric_link_error_isolation_monitor");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] next_runs(input bit bad, input logic [7:0] bad_thr,
                                              input logic [7:0] good_thr,
                                              input logic [7:0] bad_run,
                                              input logic [7:0] good_run);
        logic [7:0] b;
        logic [7:0] g;
        b = bad_run;
        g = good_run;
        if (bad)
        begin
            if (b < bad_thr)
            begin
                b = b + 8'd1;
                g = 8'd0;
            end
        end
        else if (g < good_thr)
        begin
            g = g + 8'd1;
            b = 8'd0;
        end
        return {b, g};
    endfunction

    function automatic out_t predict_poll_result(input in_t p, input bit test);
        out_t        r;
        lane_state_t s;
        logic [7:0]  lim;
        logic [7:0]  cthr;
        logic [7:0]  fthr;
        logic [63:0] drx;
        logic [63:0] dcrc;
        logic [63:0] dfec;
        logic [95:0] lhs;
        logic [95:0] rhs;
        bit          over;
        r = '0;
        r.lane_out = p.lane;
        s = lane_db[p.lane];
        over = 1'b0;
        lim = test ? TEST_SKIP_LIMIT : cfg_skip;
        cthr = cfg_crc_isolate;
        fthr = cfg_fec_isolate;

        if (s.crc_skip < lim)
        begin
            s.crc_skip = s.crc_skip + 8'd1;
            s.last_crc = p.crc_error_cells;
        end
        else
        begin
            drx = p.rx_cell_count - s.last_rx;
            if (test)
            begin
                dcrc = p.inj_crc_errors - s.last_crc;
                s.last_crc = '0;
                if (cthr != 8'hFF)
                    cthr = cthr + 8'd1;
            end
            else
            begin
                dcrc = p.crc_error_cells - s.last_crc;
                s.last_crc = p.crc_error_cells;
            end
            lhs = {32'd0, dcrc} * {64'd0, cfg_rate_rx};
            rhs = {32'd0, drx} * {64'd0, cfg_rate_crc};
            over = (lhs > rhs);
            {s.crc_bad, s.crc_good} = next_runs(over, cthr, cfg_crc_recover,
                                                s.crc_bad, s.crc_good);
        end
        s.last_rx = p.rx_cell_count;

        if (s.fec_skip < lim)
        begin
            s.fec_skip = s.fec_skip + 8'd1;
            s.last_fec = p.fec_uncorrectable;
        end
        else
        begin
            if (test)
            begin
                dfec = p.test_fec_errors - s.last_fec;
                s.last_fec = '0;
                if (fthr != 8'hFF)
                    fthr = fthr + 8'd1;
            end
            else
            begin
                dfec = p.fec_uncorrectable - s.last_fec;
                s.last_fec = p.fec_uncorrectable;
            end
            {s.fec_bad, s.fec_good} = next_runs(dfec != 64'd0, fthr, cfg_fec_recover,
                                                s.fec_bad, s.fec_good);
        end

        // isolation moves only while the link is up
        if (p.link_up)
        begin
            if (!s.isolated && (s.crc_bad >= cthr || s.fec_bad >= fthr))
            begin
                s.isolated = 1'b1;
                r.isolation_event = EV_ISOLATE;
            end
            else if (s.isolated && s.crc_good >= cfg_crc_recover &&
                     s.fec_good >= cfg_fec_recover)
            begin
                s.isolated = 1'b0;
                r.isolation_event = EV_RECOVER;
            end
        end

        lane_db[p.lane] = s;
        r.isolated        = s.isolated;
        r.crc_error_polls = s.crc_bad;
        r.crc_clean_polls = s.crc_good;
        r.fec_error_polls = s.fec_bad;
        r.fec_clean_polls = s.fec_good;
        r.rate_exceeded   = over;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] lane,
                               input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: lane %0d %s mismatch: expected %0d, actual %0d",
                     $time, lane, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_t got;
        out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(out_t)-1:0];
            if (poll_results_q.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, actual %h",
                         $time, got);
                error_count++;
            end
            else
            begin
                want = poll_results_q.pop_front();
                check_field("lane_out", want.lane_out, want.lane_out, got.lane_out);
                check_field("isolated", want.lane_out, want.isolated, got.isolated);
                check_field("isolation_event", want.lane_out, want.isolation_event,
                            got.isolation_event);
                check_field("crc_error_polls", want.lane_out, want.crc_error_polls,
                            got.crc_error_polls);
                check_field("crc_clean_polls", want.lane_out, want.crc_clean_polls,
                            got.crc_clean_polls);
                check_field("fec_error_polls", want.lane_out, want.fec_error_polls,
                            got.fec_error_polls);
                check_field("fec_clean_polls", want.lane_out, want.fec_clean_polls,
                            got.fec_clean_polls);
                check_field("rate_exceeded", want.lane_out, want.rate_exceeded,
                            got.rate_exceeded);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_poll(input in_t p, input bit test);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD{1'b0}}, p};
        s_axis_tuser  <= test;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        poll_results_q.push_back(predict_poll_result(p, test));
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (poll_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CRC_ISOLATE: cfg_crc_isolate = val[7:0];
            REG_CRC_RECOVER: cfg_crc_recover = val[7:0];
            REG_FEC_ISOLATE: cfg_fec_isolate = val[7:0];
            REG_FEC_RECOVER: cfg_fec_recover = val[7:0];
            REG_RATE_CRC:    cfg_rate_crc    = val;
            REG_RATE_RX:     cfg_rate_rx     = val;
            REG_SKIP_POLLS:  cfg_skip        = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [7:0] crc_iso, input logic [7:0] crc_rec,
                                  input logic [7:0] fec_iso, input logic [7:0] fec_rec,
                                  input logic [31:0] rate_crc, input logic [31:0] rate_rx,
                                  input logic [7:0] skip);
        write_reg(REG_CRC_ISOLATE, {24'd0, crc_iso});
        write_reg(REG_CRC_RECOVER, {24'd0, crc_rec});
        write_reg(REG_FEC_ISOLATE, {24'd0, fec_iso});
        write_reg(REG_FEC_RECOVER, {24'd0, fec_rec});
        write_reg(REG_RATE_CRC, rate_crc);
        write_reg(REG_RATE_RX, rate_rx);
        write_reg(REG_SKIP_POLLS, {24'd0, skip});
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Poll generation
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_t mk_poll(input logic [7:0] lane, input logic [63:0] rx,
                                    input logic [63:0] crc, input logic [63:0] fec,
                                    input bit up, input logic [63:0] tcrc,
                                    input logic [63:0] tfec);
        in_t p;
        p.lane              = lane;
        p.rx_cell_count     = rx;
        p.crc_error_cells   = crc;
        p.fec_uncorrectable = fec;
        p.link_up           = up;
        p.inj_crc_errors    = tcrc;
        p.test_fec_errors   = tfec;
        return p;
    endfunction

    // advance one lane's cumulative counters, in bursts of bad or clean polls
    function automatic in_t next_poll(input logic [7:0] ln, output bit test);
        logic [63:0] drx;
        logic [63:0] share;
        logic [63:0] dcrc;
        bit          fec_hit;
        if ($urandom_range(7) == 0)
            src_bad[ln] = !src_bad[ln];
        if ($urandom_range(3) == 0)
            drx = {32'd0, $urandom};
        else
            drx = {32'd0, $urandom_range(0, 65535)};
        // largest CRC delta that still stays within the allowed rate
        if (cfg_rate_rx == 32'd0)
            share = 64'd0;
        else
            share = (drx * {32'd0, cfg_rate_crc}) / {32'd0, cfg_rate_rx};
        if (src_bad[ln])
            dcrc = share + 64'd1 + {32'd0, $urandom_range(0, 3)};
        else
            dcrc = $urandom_range(1) ? share : 64'd0;
        fec_hit = src_bad[ln] ? ($urandom_range(9) < 6) : ($urandom_range(9) == 0);
        src_rx[ln]  = src_rx[ln] + drx;
        src_crc[ln] = src_crc[ln] + dcrc;
        if (fec_hit)
            src_fec[ln] = src_fec[ln] + {32'd0, $urandom_range(1, 3)};
        test = ($urandom_range(19) == 0);
        return mk_poll(ln, src_rx[ln], src_crc[ln], src_fec[ln], $urandom_range(9) != 0,
                       test ? {32'd0, $urandom_range(0, 2)} : rand64(),
                       test ? {32'd0, $urandom_range(0, 1)} : rand64());
    endfunction

    function automatic logic [7:0] pick_thr(input int hi);
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'hFF;
            default: return 8'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic logic [31:0] pick_rate(input int lo, input int hi);
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_defaults();
        // reset settings: every poll still in the skip window
        send_poll(mk_poll(8'd0, '0, '0, '0, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'hFF, '1, '1, '1, 1'b1, '1, '1), 1'b1);
        send_poll(mk_poll(8'hFF, '1, '1, '1, 1'b0, '1, '1), 1'b1);
        // third injected poll is past the test skip limit
        send_poll(mk_poll(8'hFF, '0, '0, '0, 1'b1, 64'd5, '0), 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_thresholds();
        write_all_regs(8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_poll(mk_poll(8'd7, 64'd100, '0, '0, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd7, 64'd200, '0, '0, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd7, 64'd300, '0, '0, 1'b0, '0, '0), 1'b0);
        // counters running backwards wrap to huge deltas
        send_poll(mk_poll(8'd7, 64'd5, 64'd1, '0, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd7, '1, '1, '1, 1'b1, '1, '1), 1'b0);
        wait_idle();
    endtask

    task automatic test_saturated_thresholds();
        write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0, 32'd1, 8'd1);
        send_poll(mk_poll(8'd42, 64'd10, 64'd3, '0, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd42, 64'd20, 64'd4, 64'd1, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd42, 64'd30, '0, '0, 1'b1, '1, '1), 1'b1);
        send_poll(mk_poll(8'd42, '1, '1, '0, 1'b0, '0, '0), 1'b0);
        wait_idle();
        // a zero denominator can never flag a rate excess
        write_reg(REG_RATE_RX, 32'd0);
        send_poll(mk_poll(8'd42, 64'd40, 64'd1000, '0, 1'b1, '0, '0), 1'b0);
        wait_idle();
        write_reg(REG_SKIP_POLLS, 32'd255);
        send_poll(mk_poll(8'd200, 64'd1, 64'd1, 64'd1, 1'b1, '0, '0), 1'b0);
        wait_idle();
    endtask

    task automatic test_injected_counters();
        write_all_regs(8'd1, 8'd1, 8'd1, 8'd1, 32'd1, 32'd1000, 8'd5);
        send_poll(mk_poll(8'd9, 64'd1000, 64'd50, 64'd7, 1'b1, '0, '0), 1'b1);
        send_poll(mk_poll(8'd9, 64'd2000, 64'd60, 64'd8, 1'b1, '0, '0), 1'b1);
        send_poll(mk_poll(8'd9, 64'd3000, 64'd70, 64'd9, 1'b1, '0, '0), 1'b1);
        send_poll(mk_poll(8'd9, 64'd4000, 64'd80, 64'd9, 1'b1, 64'd3, 64'd2), 1'b1);
        send_poll(mk_poll(8'd9, 64'd5000, 64'd80, 64'd9, 1'b1, '0, '0), 1'b0);
        send_poll(mk_poll(8'd9, 64'd9000, 64'd80, 64'd9, 1'b1, '0, '0), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] pool [3];
        in_t        p;
        bit         test;
        for (int round = 0; round < ROUNDS; round++)
        begin
            wait_idle();
            write_all_regs(pick_thr(4), pick_thr(6), pick_thr(4), pick_thr(6),
                           pick_rate(1, 20), pick_rate(100, 5000),
                           (round == 1) ? SKIP_POLLS_DEF : 8'($urandom_range(0, 3)));
            case (round % 4)
                0: set_idling(0, 0);
                1: set_idling(49, 0);
                2: set_idling(0, 49);
                default: set_idling(23, 23);
            endcase
            for (int k = 0; k < 3; k++)
                pool[k] = 8'($urandom_range(255));
            for (int n = 0; n < ROUND_POLLS; n++)
            begin
                if (round == 0 && n == ROUND_POLLS / 2)
                    wait_idle();
                if ($urandom_range(9) == 0)
                begin
                    // noise: every field random
                    test = 1'($urandom_range(1));
                    p = mk_poll(8'($urandom_range(255)), rand64(), rand64(), rand64(),
                                1'($urandom_range(1)), rand64(), rand64());
                end
                else if ($urandom_range(19) == 0)
                    p = next_poll(8'($urandom_range(255)), test);
                else
                    p = next_poll(pool[$urandom_range(2)], test);
                send_poll(p, test);
            end
        end
        set_idling(0, 0);
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            lane_db[i] = '0;
            src_rx[i]  = '0;
            src_crc[i] = '0;
            src_fec[i] = '0;
            src_bad[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_zero_thresholds();
        test_saturated_thresholds();
        test_injected_counters();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("PASS fabric_link_error_isolation_monitor");
        else
            $display("FAIL fabric_link_error_isolation_monitor");
        $finish;
    end

endmodule
